>>> rtl/lsda_call_site_scanner_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the call-site scanner
// Shared macros for the concurrent checks of the scanner's own logic.
// ---------------------------------------------------------------------------
`ifndef LSDA_CALL_SITE_SCANNER_CORE_DEFINES_SVH
`define LSDA_CALL_SITE_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LSCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LSCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lscs_pkg.sv
// ---------------------------------------------------------------------------
// Call-site scanner package
// Encodings, status codes, register indexes and field codes of the scanner.
// ---------------------------------------------------------------------------
package lscs_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned PosWidth  = 16;

   localparam logic [7:0] ENC_ULEB = 8'h01;
   localparam logic [7:0] ENC_FIX2 = 8'h02;
   localparam logic [7:0] ENC_FIX4 = 8'h03;
   localparam logic [7:0] ENC_FIX8 = 8'h04;

   localparam logic [6:0] PAYLOAD_MASK = 7'b1111111;
   localparam logic [7:0] MORE_BIT     = 8'b10000000;

   typedef enum logic [1:0] {
      REG_SITE_ENCODING = 2'd0,
      REG_REGION_START  = 2'd1,
      REG_THROW_ADDRESS = 2'd2,
      REG_TABLE_LENGTH  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_UNSUPPORTED = 2'd1,
      STATUS_TRUNCATED   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FIELD_START  = 2'd0,
      FIELD_LENGTH = 2'd1,
      FIELD_PAD    = 2'd2,
      FIELD_ACTION = 2'd3
   } field_type;

endpackage

>>> rtl/lsda_call_site_scanner_core.sv
// ---------------------------------------------------------------------------
// Call-site table scanner
// Parses the call-site table of an exception-handling data area byte by byte
// and reports each record with its try-range and landing-pad flags.
// ---------------------------------------------------------------------------
// The block takes one table byte per cycle on the req_ side and decodes it in
// the same cycle; a result appears on the rsp_ side in the cycle after the
// beat that completes a record, and a later byte can be taken while that
// result is being taken. Only a result left waiting in the output register,
// or a configuration write in the same cycle, holds off the next beat. The
// try-range bounds are kept in registers that follow the held start and
// length, so a record's action byte may follow its pad byte in the very next
// cycle. Writing the table length restarts the scan.
`include "lsda_call_site_scanner_core_defines.svh"

module lsda_call_site_scanner_core (
   input  logic          clock,
   input  logic          reset,
   // Table bytes
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   // Decoded records
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [63:0] site_start, [127:64] site_length, [191:128] pad_offset,
   // [255:192] action_index, [256] throw_in_range, [257] has_landing_pad,
   // [263:258] zero
   output logic [263:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser,   // [1:0] status
   output logic          rsp_tlast,   // last_record
   // Configuration
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_wdata
);

   localparam int unsigned DW = lscs_pkg::DataWidth;
   localparam int unsigned PW = lscs_pkg::PosWidth;

   logic [7:0]          enc_ff;
   logic [DW-1:0]       region_ff;
   logic [DW-1:0]       throw_ff;
   logic [PW-1:0]       tlen_ff;

   lscs_pkg::field_type fld_ff, fld_in;
   logic [3:0]          bif_ff, bif_in;
   logic [DW-1:0]       acc_ff, acc_in;
   logic [DW-1:0]       start_ff, start_in;
   logic [DW-1:0]       length_ff, length_in;
   logic [DW-1:0]       pad_ff, pad_in;
   logic [DW-1:0]       sumsl_ff, sumsl_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [DW-1:0]       lo_ff, lo_in;
   logic [DW-1:0]       hi_ff, hi_in;

   logic                rvalid_ff, rvalid_in;
   logic [1:0]          rstatus_ff;
   logic [DW-1:0]       rstart_ff, rlength_ff, rpad_ff, raction_ff;
   logic                rinr_ff, rhaspad_ff, rlast_ff;

   logic                req_accept;
   logic                active;
   logic [PW-1:0]       pos_inc;
   logic                at_end;
   logic                is_uleb;
   logic                supported;
   logic [3:0]          fix_size;
   logic [6:0]          shift7;
   logic [DW-1:0]       part;
   logic [DW-1:0]       acc_new;
   logic                done;
   logic                emit;
   lscs_pkg::status_type emit_status;
   logic                inr;

   assign req_tready = (!rvalid_ff || rsp_tready) && !csr_we;
   assign req_accept = req_tvalid && req_tready;
   assign active     = pos_ff != tlen_ff;
   assign pos_inc    = pos_ff + PW'(1);
   assign at_end     = pos_inc == tlen_ff;
   assign shift7     = ({3'd0, bif_ff} << 3) - {3'd0, bif_ff};
   assign acc_new    = acc_ff | part;
   assign inr        = (throw_ff >= lo_ff) && (throw_ff < hi_ff);

   always_comb begin
      is_uleb   = 1'b0;
      supported = 1'b1;
      fix_size  = 4'd0;
      if (fld_ff == lscs_pkg::FIELD_ACTION) begin
         is_uleb = 1'b1;
      end else begin
         unique case (enc_ff)
            lscs_pkg::ENC_ULEB: is_uleb = 1'b1;
            lscs_pkg::ENC_FIX2: fix_size = 4'd2;
            lscs_pkg::ENC_FIX4: fix_size = 4'd4;
            lscs_pkg::ENC_FIX8: fix_size = 4'd8;
            default:            supported = 1'b0;
         endcase
      end
   end

   always_comb begin
      part = '0;
      done = 1'b0;
      if (is_uleb) begin
         if (bif_ff <= 4'd9) begin
            part = {57'd0, req_tdata[6:0] & lscs_pkg::PAYLOAD_MASK} << shift7[5:0];
         end
         done = (req_tdata & lscs_pkg::MORE_BIT) == 8'd0;
      end else begin
         if (bif_ff < 4'd8) begin
            part = {56'd0, req_tdata} << {bif_ff[2:0], 3'b000};
         end
         done = ({1'b0, bif_ff} + 5'd1) >= {1'b0, fix_size};
      end
   end

   always_comb begin
      fld_in      = fld_ff;
      bif_in      = bif_ff;
      acc_in      = acc_ff;
      start_in    = start_ff;
      length_in   = length_ff;
      pad_in      = pad_ff;
      sumsl_in    = sumsl_ff;
      pos_in      = pos_ff;
      lo_in       = region_ff + start_ff;
      hi_in       = region_ff + sumsl_ff;
      emit        = 1'b0;
      emit_status = lscs_pkg::STATUS_OK;
      if (csr_we) begin
         if (csr_index == lscs_pkg::REG_TABLE_LENGTH) begin
            pos_in = '0;
            fld_in = lscs_pkg::FIELD_START;
            bif_in = '0;
            acc_in = '0;
         end
         if (csr_index == lscs_pkg::REG_REGION_START) begin
            lo_in = csr_wdata + start_ff;
            hi_in = csr_wdata + sumsl_ff;
         end
      end else if (req_accept && active) begin
         pos_in = pos_inc;
         if (!supported) begin
            fld_in      = lscs_pkg::FIELD_START;
            bif_in      = '0;
            acc_in      = '0;
            emit        = 1'b1;
            emit_status = lscs_pkg::STATUS_UNSUPPORTED;
         end else if (!done) begin
            acc_in = acc_new;
            if (bif_ff != 4'd15) begin
               bif_in = bif_ff + 4'd1;
            end
            if (at_end) begin
               fld_in      = lscs_pkg::FIELD_START;
               bif_in      = '0;
               acc_in      = '0;
               emit        = 1'b1;
               emit_status = lscs_pkg::STATUS_TRUNCATED;
            end
         end else begin
            bif_in = '0;
            acc_in = '0;
            unique case (fld_ff)
               lscs_pkg::FIELD_START: begin
                  start_in = acc_new;
                  fld_in   = lscs_pkg::FIELD_LENGTH;
               end
               lscs_pkg::FIELD_LENGTH: begin
                  length_in = acc_new;
                  sumsl_in  = start_ff + acc_new;
                  fld_in    = lscs_pkg::FIELD_PAD;
               end
               lscs_pkg::FIELD_PAD: begin
                  pad_in = acc_new;
                  fld_in = lscs_pkg::FIELD_ACTION;
               end
               default: begin
                  fld_in = lscs_pkg::FIELD_START;
                  emit   = 1'b1;
               end
            endcase
            if (at_end && fld_ff != lscs_pkg::FIELD_ACTION) begin
               fld_in      = lscs_pkg::FIELD_START;
               emit        = 1'b1;
               emit_status = lscs_pkg::STATUS_TRUNCATED;
            end
         end
      end
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (emit) begin
         rvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff    <= lscs_pkg::ENC_ULEB;
         region_ff <= '0;
         throw_ff  <= '0;
         tlen_ff   <= '0;
         fld_ff    <= lscs_pkg::FIELD_START;
         bif_ff    <= '0;
         acc_ff    <= '0;
         start_ff  <= '0;
         length_ff <= '0;
         pad_ff    <= '0;
         sumsl_ff  <= '0;
         pos_ff    <= '0;
         lo_ff     <= '0;
         hi_ff     <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               lscs_pkg::REG_SITE_ENCODING: enc_ff    <= csr_wdata[7:0];
               lscs_pkg::REG_REGION_START:  region_ff <= csr_wdata;
               lscs_pkg::REG_THROW_ADDRESS: throw_ff  <= csr_wdata;
               default:                     tlen_ff   <= csr_wdata[PW-1:0];
            endcase
         end
         fld_ff    <= fld_in;
         bif_ff    <= bif_in;
         acc_ff    <= acc_in;
         start_ff  <= start_in;
         length_ff <= length_in;
         pad_ff    <= pad_in;
         sumsl_ff  <= sumsl_in;
         pos_ff    <= pos_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rstatus_ff <= emit_status;
         rlast_ff   <= at_end;
         if (emit_status == lscs_pkg::STATUS_OK) begin
            rstart_ff  <= start_ff;
            rlength_ff <= length_ff;
            rpad_ff    <= pad_ff;
            raction_ff <= acc_new;
            rinr_ff    <= inr;
            rhaspad_ff <= pad_ff != '0;
         end else begin
            rstart_ff  <= '0;
            rlength_ff <= '0;
            rpad_ff    <= '0;
            raction_ff <= '0;
            rinr_ff    <= 1'b0;
            rhaspad_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {6'd0, rhaspad_ff, rinr_ff, raction_ff, rpad_ff, rlength_ff, rstart_ff};
   assign rsp_tuser  = rstatus_ff;
   assign rsp_tlast  = rlast_ff;

   `LSCS_ASSERT_NOW(a_pos_within_table, clock, reset,
      1'b1, pos_ff <= tlen_ff,
      "table position has run past the table length")
   `LSCS_ASSERT_NOW(a_record_needs_bytes, clock, reset,
      fld_ff != lscs_pkg::FIELD_START || bif_ff != 4'd0, pos_ff != '0,
      "a record is in progress although no byte has been consumed")
   `LSCS_ASSERT_NEXT(a_idle_byte_ignored, clock, reset,
      req_accept && !active && !csr_we, pos_ff == $past(pos_ff) && fld_ff == $past(fld_ff),
      "a beat beyond the table end changed the scan state")
   `LSCS_ASSERT_NOW(a_truncation_at_end, clock, reset,
      rvalid_ff && rstatus_ff == lscs_pkg::STATUS_TRUNCATED, rlast_ff && !rinr_ff,
      "a truncated-table result does not mark the table end")

endmodule

>>> sim/lsda_call_site_scanner_core_test.sv
// ---------------------------------------------------------------------------
// Call-site scanner testbench
// Feeds call-site tables to the scanner one byte per beat, under each
// encoding and with truncated, noisy and restarted tables, and compares
// every decoded record with a cycle-free model of the parser.
// ---------------------------------------------------------------------------

typedef struct {
   lscs_pkg::status_type status;
   logic [63:0]          start;
   logic [63:0]          length;
   logic [63:0]          pad;
   logic [63:0]          action;
   logic                 throw_hit;
   logic                 has_pad;
   logic                 tail;
} call_site_result_type;

class call_site_scoreboard;
   logic [7:0]           encoding;
   logic [63:0]          region_base;
   logic [63:0]          throw_addr;
   logic [15:0]          table_bytes;
   lscs_pkg::field_type  field;
   logic [3:0]           byte_idx;
   logic [63:0]          acc;
   logic [63:0]          start_val;
   logic [63:0]          length_val;
   logic [63:0]          pad_val;
   logic [15:0]          position;
   call_site_result_type pending[$];
   int                   errors;
   int                   consumed;

   function new();
      encoding    = lscs_pkg::ENC_ULEB;
      region_base = '0;
      throw_addr  = '0;
      table_bytes = '0;
      start_val   = '0;
      length_val  = '0;
      pad_val     = '0;
      position    = '0;
      errors      = 0;
      consumed    = 0;
      clear_record();
   endfunction

   function void clear_record();
      field    = lscs_pkg::FIELD_START;
      byte_idx = '0;
      acc      = '0;
   endfunction

   function void write_reg(lscs_pkg::reg_index_type idx, logic [63:0] value);
      case (idx)
         lscs_pkg::REG_SITE_ENCODING: encoding = value[7:0];
         lscs_pkg::REG_REGION_START:  region_base = value;
         lscs_pkg::REG_THROW_ADDRESS: throw_addr = value;
         lscs_pkg::REG_TABLE_LENGTH: begin
            table_bytes = value[15:0];
            position    = '0;
            clear_record();
         end
      endcase
   endfunction

   function void push_error(lscs_pkg::status_type status, logic tail);
      call_site_result_type r;
      r.status    = status;
      r.start     = '0;
      r.length    = '0;
      r.pad       = '0;
      r.action    = '0;
      r.throw_hit = 1'b0;
      r.has_pad   = 1'b0;
      r.tail      = tail;
      pending.push_back(r);
   endfunction

   function void note_byte(logic [7:0] b);
      logic                 uleb;
      logic                 complete;
      logic                 tail;
      int unsigned          width_bytes;
      int unsigned          shift;
      logic [63:0]          lo;
      logic [63:0]          hi;
      call_site_result_type r;
      if (position >= table_bytes) return;
      consumed++;
      position    = position + 16'd1;
      tail        = (position == table_bytes);
      uleb        = 1'b1;
      width_bytes = 0;
      if (field != lscs_pkg::FIELD_ACTION) begin
         case (encoding)
            lscs_pkg::ENC_ULEB: uleb = 1'b1;
            lscs_pkg::ENC_FIX2: begin
               uleb        = 1'b0;
               width_bytes = 2;
            end
            lscs_pkg::ENC_FIX4: begin
               uleb        = 1'b0;
               width_bytes = 4;
            end
            lscs_pkg::ENC_FIX8: begin
               uleb        = 1'b0;
               width_bytes = 8;
            end
            default: begin
               clear_record();
               push_error(lscs_pkg::STATUS_UNSUPPORTED, tail);
               return;
            end
         endcase
      end
      if (uleb) begin
         shift = 7 * byte_idx;
         if (shift < 64) acc = acc | ({57'd0, b[6:0]} << shift);
         complete = ~b[7];
      end else begin
         shift = 8 * byte_idx;
         if (shift < 64) acc = acc | ({56'd0, b} << shift);
         complete = (32'(byte_idx) + 1 >= width_bytes);
      end
      if (!complete) begin
         if (byte_idx < 4'd15) byte_idx = byte_idx + 4'd1;
         if (tail) begin
            clear_record();
            push_error(lscs_pkg::STATUS_TRUNCATED, 1'b1);
         end
         return;
      end
      case (field)
         lscs_pkg::FIELD_START: begin
            start_val = acc;
            field     = lscs_pkg::FIELD_LENGTH;
         end
         lscs_pkg::FIELD_LENGTH: begin
            length_val = acc;
            field      = lscs_pkg::FIELD_PAD;
         end
         lscs_pkg::FIELD_PAD: begin
            pad_val = acc;
            field   = lscs_pkg::FIELD_ACTION;
         end
         default: begin
            lo          = region_base + start_val;
            hi          = lo + length_val;
            r.status    = lscs_pkg::STATUS_OK;
            r.start     = start_val;
            r.length    = length_val;
            r.pad       = pad_val;
            r.action    = acc;
            r.throw_hit = (throw_addr >= lo) && (throw_addr < hi);
            r.has_pad   = (pad_val != 0);
            r.tail      = tail;
            pending.push_back(r);
            clear_record();
            return;
         end
      endcase
      byte_idx = '0;
      acc      = '0;
      if (tail) begin
         clear_record();
         push_error(lscs_pkg::STATUS_TRUNCATED, 1'b1);
      end
   endfunction

   task report(string msg);
      $display("error at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task check_result(logic [263:0] data, logic [1:0] user, logic tail);
      call_site_result_type want;
      if (pending.size() == 0) begin
         report($sformatf("record with nothing expected, status %0d", user));
         return;
      end
      want = pending.pop_front();
      if (user !== want.status)
         report($sformatf("status %0d, expected %0d", user, want.status));
      if (data[63:0] !== want.start)
         report($sformatf("site_start %h, expected %h", data[63:0], want.start));
      if (data[127:64] !== want.length)
         report($sformatf("site_length %h, expected %h", data[127:64], want.length));
      if (data[191:128] !== want.pad)
         report($sformatf("pad_offset %h, expected %h", data[191:128], want.pad));
      if (data[255:192] !== want.action)
         report($sformatf("action_index %h, expected %h", data[255:192], want.action));
      if (data[256] !== want.throw_hit)
         report($sformatf("throw_in_range %b, expected %b", data[256], want.throw_hit));
      if (data[257] !== want.has_pad)
         report($sformatf("has_landing_pad %b, expected %b", data[257], want.has_pad));
      if (data[263:258] !== 6'd0)
         report($sformatf("filler bits %b are not zero", data[263:258]));
      if (tail !== want.tail)
         report($sformatf("last_record %b, expected %b", tail, want.tail));
   endtask
endclass

module lsda_call_site_scanner_core_test;
   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'd0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [263:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_index  = 2'd0;
   logic [63:0]  csr_wdata  = 64'd0;

   call_site_scoreboard board = new();
   logic [7:0]  site_bytes[$];
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   lsda_call_site_scanner_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.write_reg(lscs_pkg::reg_index_type'(csr_index), csr_wdata);
         if (req_tvalid && req_tready) board.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic set_idling(int mode);
      case (mode)
         0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct  = 80;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 80;
         end
         default: begin
            send_idle_pct  = 32;
            recv_stall_pct = 32;
         end
      endcase
   endtask

   task automatic csr_write(lscs_pkg::reg_index_type idx, logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = 0;
      while (gap < 24 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_bytes(int from, int upto);
      for (int i = from; i < upto && i < site_bytes.size(); i++) send_byte(site_bytes[i]);
   endtask

   // Waits until every record owed by the scanner has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic scan(logic [7:0] enc, logic [15:0] len);
      csr_write(lscs_pkg::REG_SITE_ENCODING, {56'd0, enc});
      csr_write(lscs_pkg::REG_TABLE_LENGTH, {48'd0, len});
      send_bytes(0, site_bytes.size());
      drain();
   endtask

   function automatic void add_value(logic [63:0] v, logic [7:0] enc, int unsigned extra);
      int unsigned total;
      logic [63:0] rest;
      logic [7:0]  b;
      case (enc)
         lscs_pkg::ENC_FIX2: total = 2;
         lscs_pkg::ENC_FIX4: total = 4;
         lscs_pkg::ENC_FIX8: total = 8;
         default: begin
            total = 1;
            rest  = v >> 7;
            while (rest != 0) begin
               total++;
               rest = rest >> 7;
            end
            total = total + extra;
         end
      endcase
      for (int unsigned i = 0; i < total; i++) begin
         if (enc == lscs_pkg::ENC_FIX2 || enc == lscs_pkg::ENC_FIX4
               || enc == lscs_pkg::ENC_FIX8) begin
            b = 8'(v >> (8 * i));
         end else begin
            b = (7 * i < 64) ? {1'b0, 7'(v >> (7 * i))} : 8'd0;
            if (i + 1 < total) b = b | lscs_pkg::MORE_BIT;
         end
         site_bytes.push_back(b);
      end
   endfunction

   function automatic logic [63:0] pick_value(logic [7:0] enc);
      logic [63:0] v;
      case ($urandom_range(0, 5))
         0:       v = '0;
         1:       v = '1;
         2:       v = 64'($urandom_range(1, 255));
         3:       v = 64'($urandom);
         default: v = {$urandom, $urandom};
      endcase
      case (enc)
         lscs_pkg::ENC_FIX2: v = v & 64'hFFFF;
         lscs_pkg::ENC_FIX4: v = v & 64'hFFFF_FFFF;
         default: ;
      endcase
      return v;
   endfunction

   function automatic int unsigned pick_padding();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : 0;
   endfunction

   function automatic logic [7:0] pick_unsupported();
      return $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(5, 255));
   endfunction

   task automatic random_table();
      logic [7:0]  enc;
      logic [7:0]  enc2;
      logic [63:0] base;
      logic [63:0] thr;
      logic [63:0] s;
      logic [63:0] l;
      logic [63:0] s0;
      logic [63:0] l0;
      logic [63:0] lo;
      int          n_rec;
      int          len;
      int          stop;
      int          split;
      enc = ($urandom_range(0, 19) == 0) ? pick_unsupported() : 8'($urandom_range(1, 4));
      n_rec = $urandom_range(1, 4);
      site_bytes.delete();
      s0 = '0;
      l0 = '0;
      for (int i = 0; i < n_rec; i++) begin
         s = pick_value(enc);
         l = pick_value(enc);
         if (i == 0) begin
            s0 = s;
            l0 = l;
         end
         add_value(s, enc, pick_padding());
         add_value(l, enc, pick_padding());
         add_value(($urandom_range(0, 2) == 0) ? 64'd0 : pick_value(enc), enc, pick_padding());
         add_value(pick_value(lscs_pkg::ENC_ULEB), lscs_pkg::ENC_ULEB, pick_padding());
      end
      if ($urandom_range(0, 9) == 0) begin
         site_bytes.delete();
         repeat ($urandom_range(1, 24)) site_bytes.push_back(8'($urandom));
      end
      base = ($urandom_range(0, 4) == 0) ? 64'd0 : {$urandom, $urandom};
      lo   = base + s0;
      case ($urandom_range(0, 5))
         0:       thr = lo;
         1:       thr = lo + l0 - 64'd1;
         2:       thr = lo + l0;
         3:       thr = lo - 64'd1;
         4:       thr = lo + ((l0 == 0) ? 64'd0 : {$urandom, $urandom} % l0);
         default: thr = {$urandom, $urandom};
      endcase
      len = site_bytes.size();
      case ($urandom_range(0, 9))
         0: len = $urandom_range(1, len);
         1: begin
            repeat ($urandom_range(1, 6)) site_bytes.push_back(8'($urandom));
            len = site_bytes.size();
         end
         default: ;
      endcase
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) site_bytes.push_back(8'($urandom));
      stop = site_bytes.size();
      if ($urandom_range(0, 9) == 0) stop = $urandom_range(0, stop - 1);
      split = 0;
      if ($urandom_range(0, 7) == 0 && stop > 1) split = $urandom_range(1, stop - 1);
      enc2 = ($urandom_range(0, 9) == 0) ? pick_unsupported() : 8'($urandom_range(1, 4));

      csr_write(lscs_pkg::REG_SITE_ENCODING, {56'd0, enc});
      csr_write(lscs_pkg::REG_REGION_START, base);
      csr_write(lscs_pkg::REG_THROW_ADDRESS, thr);
      csr_write(lscs_pkg::REG_TABLE_LENGTH, 64'(len));
      if (split > 0) begin
         send_bytes(0, split);
         drain();
         csr_write(lscs_pkg::REG_SITE_ENCODING, {56'd0, enc2});
         send_bytes(split, stop);
      end else begin
         send_bytes(0, stop);
      end
      drain();
   endtask

   initial begin
      int random_from;
      int tables;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the table is empty, so these bytes are dropped.
      site_bytes = '{8'h55, 8'hAA};
      send_bytes(0, 2);
      drain();

      csr_write(lscs_pkg::REG_REGION_START, 64'h1000);
      csr_write(lscs_pkg::REG_THROW_ADDRESS, 64'h1010);
      site_bytes = '{8'h10, 8'h20, 8'h00, 8'h00, 8'hFF};
      scan(lscs_pkg::ENC_ULEB, 16'd4);

      csr_write(lscs_pkg::REG_REGION_START, '1);
      csr_write(lscs_pkg::REG_THROW_ADDRESS, 64'd0);
      site_bytes = '{8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h7F};
      scan(lscs_pkg::ENC_FIX2, 16'd7);

      site_bytes = '{8'h00};
      scan(8'd0, 16'd2);
      site_bytes = '{8'h80};
      csr_write(lscs_pkg::REG_SITE_ENCODING, 64'd255);
      send_bytes(0, 1);
      drain();

      site_bytes = '{8'h80, 8'h80};
      scan(lscs_pkg::ENC_ULEB, 16'd2);

      // A wide field left part-way is finished by a narrower encoding.
      site_bytes = '{8'h11, 8'h22, 8'h33};
      scan(lscs_pkg::ENC_FIX8, 16'd4);
      site_bytes = '{8'h44};
      csr_write(lscs_pkg::REG_SITE_ENCODING, {56'd0, lscs_pkg::ENC_FIX2});
      send_bytes(0, 1);
      drain();

      site_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h7F};
      scan(lscs_pkg::ENC_ULEB, 16'hFFFF);
      site_bytes = '{8'h00};
      scan(lscs_pkg::ENC_ULEB, 16'd0);

      random_from = board.consumed;
      tables      = 0;
      while (board.consumed - random_from < 1300) begin
         set_idling((tables / 6) % 4);
         random_table();
         tables++;
      end

      set_idling(0);
      drain();
      repeat (8) @(posedge clock);
      if (board.pending.size() != 0)
         board.report($sformatf("%0d records never arrived", board.pending.size()));
      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
